// File: rtl/core/fpsc_pkg.sv
// Package for the table-interpolated sine/cosine pipeline.
// Holds mode codes, angle constants, the sine table and the stage structs.
// No dependencies.
package fpsc_pkg;

  typedef enum logic [2:0] {
    MODE_SIN_FP6 = 3'd0,
    MODE_COS_FP6 = 3'd1,
    MODE_SIN_FP8 = 3'd2,
    MODE_COS_FP8 = 3'd3,
    MODE_SIN_FP9 = 3'd4
  } mode_t;

  // Fraction format of the folded angle; FMT_NONE marks an unused mode.
  typedef enum logic [1:0] {
    FMT_FP6  = 2'd0,
    FMT_FP8  = 2'd1,
    FMT_FP9  = 2'd2,
    FMT_NONE = 2'd3
  } frac_fmt_t;

  localparam int AW = 18;  // working width of angle arithmetic

  localparam logic signed [AW-1:0] DEG720_FP6 = 18'sd46080;
  localparam logic signed [AW-1:0] DEG360_FP6 = 18'sd23040;
  localparam logic signed [AW-1:0] DEG270_FP6 = 18'sd17280;
  localparam logic signed [AW-1:0] DEG180_FP6 = 18'sd11520;
  localparam logic signed [AW-1:0] DEG90_FP6  = 18'sd5760;
  localparam logic signed [AW-1:0] DEG180_FP8 = 18'sd46080;
  localparam logic signed [AW-1:0] DEG90_FP8  = 18'sd23040;
  localparam logic signed [AW-1:0] DEG120_FP8 = 18'sd30720;
  localparam logic signed [AW-1:0] DEG30_FP9  = 18'sd15360;

  localparam logic [7:0] LAST_INDEX = 8'd22;

  // Folded first-quadrant angle, between reduce and interp.
  typedef struct packed {
    logic      vld;
    logic [15:0] qa;
    frac_fmt_t fmt;
    logic      neg;
    logic      oor;
  } quad_t;

  // Final result at the output register.
  typedef struct packed {
    logic        vld;
    logic [15:0] value;
    logic        oor;
  } res_t;

  // Q14 sine at 4 degree steps; last entry raised so 90 degrees hits 1.0.
  function automatic logic [14:0] sine_entry(input logic [4:0] idx);
    logic [14:0] v;
    case (idx)
      5'd0:  v = 15'd0;
      5'd1:  v = 15'd1143;
      5'd2:  v = 15'd2280;
      5'd3:  v = 15'd3406;
      5'd4:  v = 15'd4516;
      5'd5:  v = 15'd5604;
      5'd6:  v = 15'd6664;
      5'd7:  v = 15'd7692;
      5'd8:  v = 15'd8682;
      5'd9:  v = 15'd9630;
      5'd10: v = 15'd10531;
      5'd11: v = 15'd11381;
      5'd12: v = 15'd12176;
      5'd13: v = 15'd12911;
      5'd14: v = 15'd13583;
      5'd15: v = 15'd14189;
      5'd16: v = 15'd14726;
      5'd17: v = 15'd15191;
      5'd18: v = 15'd15582;
      5'd19: v = 15'd15897;
      5'd20: v = 15'd16135;
      5'd21: v = 15'd16294;
      5'd22: v = 15'd16374;
      5'd23: v = 15'd16394;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/fpsc_reduce.sv
// Angle reduction: modulo 360 for fp6, range flag, fold into first quadrant.
// Two register stages. Depends on fpsc_pkg.
module fpsc_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [2:0]         mode,
  input  logic signed [15:0] angle,
  output fpsc_pkg::quad_t    quad
);
  import fpsc_pkg::*;

  // Stage 1 registers
  logic                 s1_vld;
  mode_t                s1_mode;
  logic signed [AW-1:0] s1_a;
  logic                 s1_oor;

  logic signed [AW-1:0] a_ext;
  logic signed [AW-1:0] a_sh;
  logic signed [AW-1:0] s1_a_next;
  logic                 s1_oor_next;
  mode_t                mode_in;

  assign mode_in = mode_t'(mode);
  assign a_ext   = {{(AW-16){angle[15]}}, angle};

  always_comb begin
    a_sh        = (mode_in == MODE_COS_FP6) ? a_ext + DEG90_FP6 : a_ext;
    s1_a_next   = a_ext;
    s1_oor_next = 1'b0;
    if (mode_in inside {MODE_SIN_FP6, MODE_COS_FP6}) begin
      if (a_sh < -DEG360_FP6)      s1_a_next = a_sh + DEG720_FP6;
      else if (a_sh < 0)           s1_a_next = a_sh + DEG360_FP6;
      else if (a_sh >= DEG360_FP6) s1_a_next = a_sh - DEG360_FP6;
      else                         s1_a_next = a_sh;
    end
    case (mode_in)
      MODE_SIN_FP6, MODE_COS_FP6: s1_oor_next = 1'b0;
      MODE_SIN_FP8, MODE_COS_FP8:
        s1_oor_next = (a_ext > DEG120_FP8) || (a_ext < -DEG120_FP8);
      MODE_SIN_FP9:
        s1_oor_next = (a_ext > DEG30_FP9) || (a_ext < -DEG30_FP9);
      default: s1_oor_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode <= mode_in;
      s1_a    <= s1_a_next;
      s1_oor  <= s1_oor_next;
    end
  end

  // Stage 2: fold to a non-negative first-quadrant angle
  quad_t                quad_next;
  logic signed [AW-1:0] q;
  logic                 neg;
  frac_fmt_t            fmt;

  always_comb begin
    q   = s1_a;
    neg = 1'b0;
    fmt = FMT_NONE;
    case (s1_mode)
      MODE_SIN_FP6, MODE_COS_FP6: begin
        fmt = FMT_FP6;
        if (s1_a > DEG270_FP6) begin
          q = DEG360_FP6 - s1_a; neg = 1'b1;
        end else if (s1_a > DEG180_FP6) begin
          q = s1_a - DEG180_FP6; neg = 1'b1;
        end else if (s1_a > DEG90_FP6) begin
          q = DEG180_FP6 - s1_a;
        end else begin
          q = s1_a;
        end
      end
      MODE_SIN_FP8: begin
        fmt = FMT_FP8;
        if (s1_a >= DEG90_FP8) begin
          q = DEG180_FP8 - s1_a;
        end else if (s1_a >= 0) begin
          q = s1_a;
        end else if (s1_a >= -DEG90_FP8) begin
          q = -s1_a; neg = 1'b1;
        end else begin
          q = DEG180_FP8 + s1_a; neg = 1'b1;
        end
      end
      MODE_COS_FP8: begin
        fmt = FMT_FP8;
        if (s1_a >= DEG90_FP8) begin
          q = s1_a - DEG90_FP8; neg = 1'b1;
        end else if (s1_a >= 0) begin
          q = DEG90_FP8 - s1_a;
        end else if (s1_a >= -DEG90_FP8) begin
          q = s1_a + DEG90_FP8;
        end else begin
          q = -s1_a - DEG90_FP8; neg = 1'b1;
        end
      end
      MODE_SIN_FP9: begin
        fmt = FMT_FP9;
        if (s1_a >= 0) begin
          q = s1_a;
        end else begin
          q = -s1_a; neg = 1'b1;
        end
      end
      default: begin
        q   = '0;
        fmt = FMT_NONE;
      end
    endcase
    quad_next.vld = s1_vld;
    quad_next.qa  = q[15:0];
    quad_next.fmt = fmt;
    quad_next.neg = neg;
    quad_next.oor = s1_oor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad.vld <= 1'b0;
    end else if (en) begin
      quad <= quad_next;
    end
  end

endmodule

// File: rtl/core/fpsc_interp.sv
// Table lookup and linear interpolation: lookup, multiply, sum and sign.
// Three register stages, the last is the output register. Depends on fpsc_pkg.
module fpsc_interp (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  fpsc_pkg::quad_t quad,
  output fpsc_pkg::res_t  res
);
  import fpsc_pkg::*;

  // Stage 3: index, fraction, table entries
  logic        s3_vld;
  logic [14:0] s3_lo;
  logic [10:0] s3_diff;
  logic [10:0] s3_frac;
  logic        s3_neg;
  logic        s3_zero;
  logic        s3_oor;

  logic [7:0]  idx_raw;
  logic [4:0]  idx;
  logic [10:0] frac_next;
  logic [14:0] lo_next;
  logic [14:0] hi_next;

  // Fraction is scaled up to 11 bits so one shift of 11 serves all formats.
  always_comb begin
    case (quad.fmt)
      FMT_FP6: begin
        idx_raw   = quad.qa[15:8];
        frac_next = {quad.qa[7:0], 3'b000};
      end
      FMT_FP8: begin
        idx_raw   = {2'b00, quad.qa[15:10]};
        frac_next = {quad.qa[9:0], 1'b0};
      end
      FMT_FP9: begin
        idx_raw   = {3'b000, quad.qa[15:11]};
        frac_next = quad.qa[10:0];
      end
      default: begin
        idx_raw   = '0;
        frac_next = '0;
      end
    endcase
    idx     = (idx_raw > LAST_INDEX) ? LAST_INDEX[4:0] : idx_raw[4:0];
    lo_next = sine_entry(idx);
    hi_next = sine_entry(idx + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= quad.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_lo   <= lo_next;
      s3_diff <= 11'(hi_next - lo_next);
      s3_frac <= frac_next;
      s3_neg  <= quad.neg;
      s3_zero <= (quad.fmt == FMT_NONE);
      s3_oor  <= quad.oor;
    end
  end

  // Stage 4: product of fraction and entry difference
  logic        s4_vld;
  logic [21:0] s4_prod;
  logic [14:0] s4_lo;
  logic        s4_neg;
  logic        s4_zero;
  logic        s4_oor;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_prod <= 22'(s3_frac) * 22'(s3_diff);
      s4_lo   <= s3_lo;
      s4_neg  <= s3_neg;
      s4_zero <= s3_zero;
      s4_oor  <= s3_oor;
    end
  end

  // Stage 5: add, apply sign, hold in the output register
  logic [15:0] mag;
  logic [15:0] value_next;

  always_comb begin
    mag = 16'(s4_lo) + 16'(s4_prod[21:11]);
    if (s4_zero)     value_next = '0;
    else if (s4_neg) value_next = 16'(-mag);
    else             value_next = mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.vld <= 1'b0;
    end else if (en) begin
      res.vld   <= s4_vld;
      res.value <= value_next;
      res.oor   <= s4_oor;
    end
  end

endmodule

// File: rtl/core/fixed_point_sine_cosine_top.sv
// Fixed-point sine/cosine: five-stage pipeline, table lookup with interpolation.
// Throughput: one transfer per cycle; the whole pipeline holds while out_stall
// blocks a waiting result, which is the only source of backpressure.
// Reset (rst, synchronous, active high) clears every stage valid bit.
// Depends on fpsc_pkg, fpsc_reduce and fpsc_interp.
module fixed_point_sine_cosine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] value,
  output logic               out_of_range
);
  import fpsc_pkg::*;

  logic  adv;
  quad_t quad;
  res_t  res;

  // Advance all stages together unless the output register holds a result
  // that the downstream side is not taking. Bubbles move on with the data.
  assign adv      = !res.vld || !out_stall;
  assign in_stall = !adv;

  // Stages 1-2: reduce modulo 360 (fp6), flag range, fold to first quadrant.
  fpsc_reduce u_reduce (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_vld (in_valid),
    .mode   (mode),
    .angle  (angle),
    .quad   (quad)
  );

  // Stages 3-5: table read, multiply by fraction, add and apply sign.
  fpsc_interp u_interp (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .quad (quad),
    .res  (res)
  );

  // Drive ports straight from the output register.
  assign out_valid    = res.vld;
  assign value        = res.value;
  assign out_of_range = res.oor;

endmodule

// File: rtl/core/fpsc_checker.sv
// Port-level checks for the sine/cosine pipeline, bound to the top level.
// Depends on fpsc_pkg (mode codes) and fixed_point_sine_cosine_top ports.
module fpsc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] value,
  input logic               out_of_range
);
  import fpsc_pkg::*;

  // Backpressure only ever comes from a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // Hold a blocked result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(value) && $stable(out_of_range)))
    else $error("blocked result changed");

  // Unused mode gives zero and the range flag once it has passed all stages unstalled.
  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode > MODE_SIN_FP9) ##1 !in_stall ##1 !in_stall
      ##1 !in_stall ##1 !in_stall
    |=> (out_valid && out_of_range && value == 16'sd0))
    else $error("unused mode result wrong");

  // Fp6 modes never flag out of range.
  a_fp6_in_range: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode <= MODE_COS_FP6) ##1 !in_stall ##1 !in_stall
      ##1 !in_stall ##1 !in_stall
    |=> (out_valid && !out_of_range))
    else $error("fp6 result flagged out of range");

endmodule

bind fixed_point_sine_cosine_top fpsc_checker u_fpsc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .mode         (mode),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .value        (value),
  .out_of_range (out_of_range)
);
